### hw/rtl/wildcard_pattern_matcher_assert.svh
// Assertion macros shared by the wildcard pattern matcher RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wildcard pattern matcher: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wildcard pattern matcher: assertion failed");

`endif

### hw/rtl/wpm_pkg.sv
package wpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;

    localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_TEXT    = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_LOAD,
        OP_STEP,
        OP_EMPTY,
        OP_SPREAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [SYM_W-1:0] symbol;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPREAD,
        ST_FINISH
    } state_t;

endpackage

### hw/rtl/wpm_cell.sv
module wpm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  wpm_pkg::cell_cmd_t cmd,
    input  logic              sel,       // this cell takes the next pattern byte
    input  logic              left_bit,  // match bit of the neighbor one prefix shorter
    output logic              match_bit
);
    import wpm_pkg::*;

    logic             bit_reg;
    logic             bit_next;
    logic             active_reg;
    logic             active_next;
    logic [SYM_W-1:0] byte_reg;
    logic [SYM_W-1:0] byte_next;
    logic             is_star;

    assign is_star   = (byte_reg == STAR_BYTE);
    assign match_bit = bit_reg;

    always_comb
    begin
        bit_next    = bit_reg;
        active_next = active_reg;
        byte_next   = byte_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                bit_next    = 1'b0;
                active_next = 1'b0;
            end
            OP_LOAD:
            begin
                if (sel)
                begin
                    byte_next   = cmd.symbol;
                    active_next = 1'b1;
                    bit_next    = left_bit && (cmd.symbol == STAR_BYTE);
                end
            end
            OP_STEP:
            begin
                // A star keeps its old bit here; the spread pass adds the left side.
                if (active_reg && !is_star)
                begin
                    bit_next = left_bit && ((byte_reg == ANY_BYTE) || (byte_reg == cmd.symbol));
                end
            end
            OP_EMPTY:
            begin
                bit_next = 1'b0;
            end
            OP_SPREAD:
            begin
                if (active_reg && is_star)
                begin
                    bit_next = bit_reg || left_bit;
                end
            end
            default:
            begin
                bit_next = bit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg    <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            bit_reg    <= bit_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

### hw/rtl/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: '?' matches any one byte, '*' any run of bytes.
// Input words carry an action in s_tuser (clear pattern, append pattern byte,
// text byte, restart text) and a byte in s_tdata. Every input word yields one
// output word with the match flag, the append error flag and the pattern length.
// A row of cells holds one pattern byte and one match bit each; cell k shows
// whether the text so far matches the first k+1 pattern bytes.
// A clear or append word goes from the finish state into the output register,
// and the next input word can be taken once it is there.
// With N pattern bytes held, a text or restart word first updates the cells
// (a text byte from their left neighbors, a restart clears their bits), then
// N spread passes move a match one cell per cycle along a run of stars.
// The finish state then writes the result to the output register.
// A new word is accepted only once the previous one has reached the output
// register, so it may be accepted while that output word still waits.
// If the receiver stalls, the finished result holds inside the block until the
// output register frees up; no word is lost or repeated.
// After reset the pattern is empty, no text has begun and an empty text
// matches the empty pattern.
module wildcard_pattern_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] matched, [1] error, [8:2] pattern_length, rest zero
);
    import wpm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] spread_reg;
    logic [CNT_W-1:0] spread_next;
    logic             row0_reg;
    logic             row0_next;
    logic             begun_reg;
    logic             begun_next;
    logic             err_reg;
    logic             err_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      out_data_reg;
    logic [15:0]      out_data_next;

    cell_cmd_t        cmd;
    action_t          action;
    logic             s_accept;
    logic             append_ok;
    logic             out_free;
    logic [PATTERN_MAX:0] row;

    assign action    = action_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign append_ok = !begun_reg && (count_reg < CNT_W'(PATTERN_MAX));
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign row[0]    = row0_reg;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            wpm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .sel       (count_reg == CNT_W'(k)),
                .left_bit  (row[k]),
                .match_bit (row[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        spread_next    = spread_reg;
        row0_next      = row0_reg;
        begun_next     = begun_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd.op         = OP_HOLD;
        cmd.symbol     = s_tdata;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    err_next    = 1'b0;
                    state_next  = ST_FINISH;
                    spread_next = count_reg;
                    case (action)
                        ACT_CLEAR:
                        begin
                            cmd.op     = OP_CLEAR;
                            row0_next  = 1'b1;
                            begun_next = 1'b0;
                            count_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (append_ok)
                            begin
                                cmd.op     = OP_LOAD;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        ACT_TEXT:
                        begin
                            cmd.op     = OP_STEP;
                            row0_next  = 1'b0;
                            begun_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                state_next = ST_SPREAD;
                            end
                        end
                        ACT_RESTART:
                        begin
                            cmd.op     = OP_EMPTY;
                            row0_next  = 1'b1;
                            begun_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_SPREAD;
                            end
                        end
                        default:
                        begin
                            cmd.op = OP_HOLD;
                        end
                    endcase
                end
            end
            ST_SPREAD:
            begin
                // Each pass moves a match one cell further along a run of stars.
                cmd.op      = OP_SPREAD;
                spread_next = spread_reg - 1'b1;
                if (spread_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, LEN_W'(count_reg), err_reg, row[count_reg]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            spread_reg    <= '0;
            row0_reg      <= 1'b1;
            begun_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            spread_reg    <= spread_next;
            row0_reg      <= row0_next;
            begun_reg     <= begun_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`include "wildcard_pattern_matcher_assert.svh"

    `WPM_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(PATTERN_MAX))
    `WPM_ASSERT_NOW(a_spread_nonzero, state_reg == ST_SPREAD, spread_reg != '0)
    `WPM_ASSERT_NEXT(a_text_clears_row0, s_accept && (action == ACT_TEXT), !row0_reg)
    `WPM_ASSERT_NEXT(a_count_only_on_accept, !s_accept, $stable(count_reg))
    `WPM_ASSERT_NEXT(a_append_error_keeps_count,
        s_accept && (action == ACT_APPEND) && !append_ok, err_reg && $stable(count_reg))

endmodule

### sim/wildcard_pattern_matcher_tb.sv
`timescale 1ns / 1ps

module wildcard_pattern_matcher_tb;
    import wpm_pkg::*;

    localparam int          RANDOM_WORDS = 1800;
    localparam logic [7:0]  SYM_A        = 8'h61;
    localparam logic [7:0]  SYM_B        = 8'h62;

    typedef struct packed {
        logic             matched;
        logic             error;
        logic [LEN_W-1:0] length;
    } match_word_t;

    typedef struct packed {
        action_t          act;
        logic [SYM_W-1:0] sym;
        logic [7:0]       reps;
        logic             typed;      // use the typed result instead of the predictor
        logic             matched;
        logic             error;
        logic [LEN_W-1:0] length;
    } plan_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] symbol
    logic [1:0]  s_tuser  = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] matched, [1] error, [8:2] pattern_length

    // Private copy of the matcher state.
    logic [SYM_W-1:0]   pat_bytes [PATTERN_MAX];
    int                 pat_len     = 0;
    logic [PATTERN_MAX:0] prefix_hits = 1;
    logic               text_open   = 1'b0;

    match_word_t pending_words [$];
    int          sent_words = 0;
    int          fail_count = 0;
    bit          calm       = 1'b0;

    plan_row_t plan [0:19] = '{
        '{ACT_RESTART, 8'h00,     8'd1,  1'b1, 1'b1, 1'b0, 7'd0},
        '{ACT_TEXT,    8'h00,     8'd1,  1'b1, 1'b0, 1'b0, 7'd0},
        '{ACT_APPEND,  8'hFF,     8'd1,  1'b1, 1'b0, 1'b1, 7'd0},
        '{ACT_CLEAR,   8'h55,     8'd1,  1'b1, 1'b1, 1'b0, 7'd0},
        '{ACT_APPEND,  STAR_BYTE, 8'd1,  1'b1, 1'b1, 1'b0, 7'd1},
        '{ACT_APPEND,  ANY_BYTE,  8'd1,  1'b1, 1'b0, 1'b0, 7'd2},
        '{ACT_APPEND,  8'hFF,     8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_TEXT,    STAR_BYTE, 8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_TEXT,    8'hFF,     8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_TEXT,    8'h00,     8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_RESTART, 8'h00,     8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_APPEND,  STAR_BYTE, 8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_TEXT,    ANY_BYTE,  8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_CLEAR,   8'hAA,     8'd1,  1'b1, 1'b1, 1'b0, 7'd0},
        '{ACT_APPEND,  STAR_BYTE, 8'd64, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_APPEND,  8'h00,     8'd1,  1'b1, 1'b1, 1'b1, 7'd64},
        '{ACT_TEXT,    8'hA5,     8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_TEXT,    STAR_BYTE, 8'd1,  1'b0, 1'b0, 1'b0, 7'd0},
        '{ACT_RESTART, 8'h00,     8'd1,  1'b1, 1'b1, 1'b0, 7'd64},
        '{ACT_CLEAR,   8'h00,     8'd1,  1'b1, 1'b1, 1'b0, 7'd0}
    };

    wildcard_pattern_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Row for empty text: a prefix matches only while it is all stars.
    function automatic void rebuild_empty_hits();
        prefix_hits    = '0;
        prefix_hits[0] = 1'b1;
        for (int j = 1; j <= pat_len; j++)
            prefix_hits[j] = prefix_hits[j-1] && (pat_bytes[j-1] == STAR_BYTE);
    endfunction

    function automatic match_word_t match_after(action_t act, logic [SYM_W-1:0] sym);
        match_word_t          res;
        logic [PATTERN_MAX:0] old_hits;
        res = '0;
        case (act)
            ACT_CLEAR:
            begin
                pat_len   = 0;
                text_open = 1'b0;
                rebuild_empty_hits();
            end
            ACT_APPEND:
            begin
                if (text_open || pat_len >= PATTERN_MAX)
                    res.error = 1'b1;
                else
                begin
                    pat_bytes[pat_len] = sym;
                    pat_len++;
                    prefix_hits[pat_len] = prefix_hits[pat_len-1] && (sym == STAR_BYTE);
                end
            end
            ACT_TEXT:
            begin
                text_open      = 1'b1;
                old_hits       = prefix_hits;
                prefix_hits[0] = 1'b0;
                for (int j = 1; j <= pat_len; j++)
                begin
                    if (pat_bytes[j-1] == STAR_BYTE)
                        prefix_hits[j] = prefix_hits[j-1] || old_hits[j];
                    else if (pat_bytes[j-1] == ANY_BYTE || pat_bytes[j-1] == sym)
                        prefix_hits[j] = old_hits[j-1];
                    else
                        prefix_hits[j] = 1'b0;
                end
            end
            default:
            begin
                text_open = 1'b0;
                rebuild_empty_hits();
            end
        endcase
        res.matched = prefix_hits[pat_len];
        res.length  = LEN_W'(pat_len);
        return res;
    endfunction

    // Holds the word on the bus until the block takes it.
    task automatic send_word(action_t act, logic [SYM_W-1:0] sym);
        while (!calm && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= sym;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words++;
    endtask

    task automatic apply(action_t act, logic [SYM_W-1:0] sym);
        send_word(act, sym);
        pending_words.push_back(match_after(act, sym));
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SYM_W-1:0] pattern_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return STAR_BYTE;
        else if (roll < 35)
            return ANY_BYTE;
        else if (roll < 90)
            return roll[0] ? SYM_A : SYM_B;
        return SYM_W'($urandom);
    endfunction

    function automatic logic [SYM_W-1:0] text_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return SYM_A;
        else if (roll < 90)
            return SYM_B;
        else if (roll < 95)
            return STAR_BYTE;
        return SYM_W'($urandom);
    endfunction

    always @(posedge clk)
    begin
        match_word_t want;
        match_word_t got;
        if (m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[1], m_tdata[8:2]};
            if (pending_words.size() == 0)
            begin
                $error("result word with no expectation: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, got.matched);
                    fail_count++;
                end
                if (got.error !== want.error)
                begin
                    $error("error: expected %0d, got %0d", want.error, got.error);
                    fail_count++;
                end
                if (got.length !== want.length)
                begin
                    $error("pattern_length: expected %0d, got %0d", want.length, got.length);
                    fail_count++;
                end
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 33);
    end

    initial
    begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int plen;
        int runs;
        int roll;
        int goal;
        bit paused;
        match_word_t got;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            repeat (plan[i].reps)
            begin
                send_word(plan[i].act, plan[i].sym);
                got = match_after(plan[i].act, plan[i].sym);
                if (plan[i].typed)
                    pending_words.push_back('{plan[i].matched, plan[i].error, plan[i].length});
                else
                    pending_words.push_back(got);
            end
        end
        hold_until_drained();

        goal = sent_words + RANDOM_WORDS;
        while (sent_words < goal)
        begin
            calm = (goal - sent_words) < 1100 && (goal - sent_words) >= 800;
            if (!paused && (goal - sent_words) < 600)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                // Noise, including appends that land after text has begun.
                repeat ($urandom_range(1, 4))
                    apply(action_t'($urandom_range(0, 3)), SYM_W'($urandom));
            end
            else
            begin
                apply(roll < 80 ? ACT_CLEAR : ACT_RESTART, SYM_W'($urandom));
                plen = ($urandom_range(99) < 8) ? $urandom_range(50, 70) : $urandom_range(0, 8);
                repeat (plen)
                    apply(ACT_APPEND, pattern_byte());
                runs = ($urandom_range(99) < 30) ? 2 : 1;
                for (int r = 0; r < runs; r++)
                begin
                    if (r > 0)
                        apply(ACT_RESTART, SYM_W'($urandom));
                    repeat ($urandom_range(0, 12))
                        apply(ACT_TEXT, text_byte());
                end
                if ($urandom_range(99) < 10)
                    apply(ACT_APPEND, pattern_byte());
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
